// ===== hw/rtl/lsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared constants, codes and the Latin-1 case fold for the substring matcher.
// ----------------------------------------------------------------------------
package lsm_pkg;

    localparam int PATTERN_BYTES_DEF = 16;
    localparam int POSITION_BITS_DEF = 16;
    localparam int START_BITS        = 16;
    localparam int LEN_BITS          = 5;
    localparam int CFG_DATA_BITS     = 64;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int PATTERN_BITS      = 128;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CASE_INSENSITIVE = 2'd3;

    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        else if (c >= 8'hC0 && c <= 8'hDE && c != 8'hD7)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/lsm_text_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_text_if
// Text byte channel: valid/ready handshake with at most one text byte per transaction.
// ----------------------------------------------------------------------------
interface lsm_text_if;
    logic        valid;
    logic        ready;
    logic [7:0]  text_byte;
    logic        has_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] start_from;

    modport source (output valid, output text_byte, output has_byte, output first_byte,
                    output last_byte, output start_from, input ready);
    modport sink   (input valid, input text_byte, input has_byte, input first_byte,
                    input last_byte, input start_from, output ready);
endinterface

// ===== hw/rtl/lsm_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_result_if
// Result channel: valid/ready handshake carrying status and match position.
// ----------------------------------------------------------------------------
interface lsm_result_if #(parameter int POSITION_BITS = 16);
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [POSITION_BITS-1:0] position;

    modport source (output valid, output status, output position, input ready);
    modport sink   (input valid, input status, input position, output ready);
endinterface

// ===== hw/rtl/latin1_substring_matcher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latin1_substring_matcher_top
// Streaming substring search over Latin-1 text with optional case folding.
//
// Channel  Dir  Handshake     Payload
// text     in   valid/ready   text_byte, has_byte, first_byte, last_byte, start_from
// result   out  valid/ready   status, position
// cfg      in   cfg_we        cfg_index, cfg_data
//
// One text byte per cycle while text.ready is high; a result passes from the input
// register through the window compare into a 2-deep result queue, whose head drives
// the result port.
// Reset clears configuration, search state and the queue; no clearing pass.
// text.ready drops only while an item waits in the input register and the
// result queue holds two results.
// ----------------------------------------------------------------------------
module latin1_substring_matcher_top #(
    parameter int PATTERN_BYTES = lsm_pkg::PATTERN_BYTES_DEF,
    parameter int POSITION_BITS = lsm_pkg::POSITION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    lsm_text_if.sink                            text,
    lsm_result_if.source                        result,
    input  logic                                cfg_we,
    input  logic [lsm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lsm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import lsm_pkg::*;

    localparam int SEEN_BITS = POSITION_BITS + 1;
    localparam int CMP_BITS  = (SEEN_BITS > START_BITS) ? SEEN_BITS : START_BITS + 1;
    localparam int IDX_BITS  = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(PATTERN_BYTES);
    localparam logic [1:0] QUEUE_EMPTY = 2'd0;
    localparam logic [1:0] QUEUE_ONE   = 2'd1;
    localparam logic [1:0] QUEUE_FULL  = 2'd2;

    // configuration
    logic [PATTERN_BITS-1:0] pattern_reg;
    logic [LEN_BITS-1:0]     length_reg;
    logic                    nocase_reg;

    // input register
    logic                    stg_valid_reg;
    logic [7:0]              stg_byte_reg;
    logic                    stg_has_reg;
    logic                    stg_first_reg;
    logic                    stg_last_reg;
    logic [START_BITS-1:0]   stg_start_reg;

    // search state
    logic [7:0]              recent_reg [PATTERN_BYTES];
    logic [SEEN_BITS-1:0]    seen_reg;
    logic [START_BITS-1:0]   off_reg;
    logic                    rep_reg;

    // result queue
    logic [1:0]               count_reg;
    logic [1:0]               count_next;
    logic [1:0]               q0_status_reg;
    logic [POSITION_BITS-1:0] q0_position_reg;
    logic [1:0]               q1_status_reg;
    logic [POSITION_BITS-1:0] q1_position_reg;

    logic                    advance;
    logic                    push;
    logic                    pop;
    logic [LEN_BITS-1:0]     len_used;

    logic [7:0]              base_recent [PATTERN_BYTES];
    logic [7:0]              win [PATTERN_BYTES];
    logic [SEEN_BITS-1:0]    base_seen;
    logic [START_BITS-1:0]   base_off;
    logic                    base_rep;
    logic                    in_range;
    logic [SEEN_BITS-1:0]    idx_inc;
    logic [SEEN_BITS-1:0]    seen_next;
    logic                    miss;
    logic [LEN_BITS-1:0]     tap;
    logic [7:0]              pb;
    logic [7:0]              tb;
    logic [CMP_BITS-1:0]     idx_c;
    logic [CMP_BITS-1:0]     inc_c;
    logic [CMP_BITS-1:0]     len_c;
    logic [CMP_BITS-1:0]     off_c;
    logic [CMP_BITS-1:0]     begin_c;
    logic                    hit;
    logic [CMP_BITS-1:0]     hit_pos;
    logic                    last_eff;
    logic                    report_byte;
    logic                    report_end;
    logic [1:0]              res_status;
    logic [CMP_BITS-1:0]     res_pos;
    logic [POSITION_BITS-1:0] res_position;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= '0;
            nocase_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:      pattern_reg[CFG_DATA_BITS-1:0] <= cfg_data;
                CFG_PATTERN_HIGH:     pattern_reg[PATTERN_BITS-1:CFG_DATA_BITS] <= cfg_data;
                CFG_PATTERN_LENGTH:   length_reg <= cfg_data[LEN_BITS-1:0];
                CFG_CASE_INSENSITIVE: nocase_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    assign len_used = (length_reg > LEN_MAX) ? LEN_MAX : length_reg;

    assign advance    = stg_valid_reg && (count_reg != QUEUE_FULL);
    assign text.ready = !stg_valid_reg || (count_reg != QUEUE_FULL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            stg_valid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            stg_byte_reg  <= text.text_byte;
            stg_has_reg   <= text.has_byte;
            stg_first_reg <= text.first_byte;
            stg_last_reg  <= text.last_byte;
            stg_start_reg <= text.start_from;
        end
    end

    always_comb
    begin
        for (int i = 0; i < PATTERN_BYTES; i++)
        begin
            base_recent[i] = stg_first_reg ? 8'h00 : recent_reg[i];
        end
        base_seen = stg_first_reg ? '0 : seen_reg;
        base_off  = stg_first_reg ? stg_start_reg : off_reg;
        base_rep  = stg_first_reg ? 1'b0 : rep_reg;

        for (int i = 0; i < PATTERN_BYTES; i++)
        begin
            if (!stg_has_reg)
                win[i] = base_recent[i];
            else if (i == 0)
                win[i] = stg_byte_reg;
            else
                win[i] = base_recent[(i > 0) ? i - 1 : 0];
        end

        in_range  = !base_seen[SEEN_BITS-1];
        idx_inc   = base_seen + SEEN_BITS'(1);
        seen_next = (stg_has_reg && in_range) ? idx_inc : base_seen;

        // window compare, newest byte holds the last pattern byte
        miss = 1'b0;
        for (int k = 0; k < PATTERN_BYTES; k++)
        begin
            tap = len_used - LEN_BITS'(1) - LEN_BITS'(k);
            pb  = pattern_reg[8*k +: 8];
            tb  = win[tap[IDX_BITS-1:0]];
            if (nocase_reg)
            begin
                pb = fold(pb);
                tb = fold(tb);
            end
            if ((LEN_BITS'(k) < len_used) && (pb != tb))
                miss = 1'b1;
        end

        idx_c   = CMP_BITS'(base_seen);
        inc_c   = CMP_BITS'(idx_inc);
        len_c   = CMP_BITS'(len_used);
        off_c   = CMP_BITS'(base_off);
        begin_c = inc_c - len_c;

        if (len_used == '0)
        begin
            hit     = (idx_c == off_c);
            hit_pos = idx_c;
        end
        else
        begin
            hit     = (inc_c >= len_c) && (begin_c >= off_c) && !miss;
            hit_pos = begin_c;
        end

        last_eff    = stg_last_reg || !stg_has_reg;
        report_byte = stg_has_reg && in_range && !base_rep && hit;
        report_end  = !report_byte && last_eff && !base_rep;

        if (report_byte)
        begin
            res_status = STATUS_FOUND;
            res_pos    = hit_pos;
        end
        else if (seen_next[SEEN_BITS-1])
        begin
            res_status = STATUS_TOO_LONG;
            res_pos    = '0;
        end
        else if ((len_used == '0) && (off_c == CMP_BITS'(seen_next)))
        begin
            res_status = STATUS_FOUND;
            res_pos    = off_c;
        end
        else
        begin
            res_status = STATUS_NOT_FOUND;
            res_pos    = '0;
        end
        res_position = res_pos[POSITION_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATTERN_BYTES; i++)
                recent_reg[i] <= 8'h00;
            seen_reg <= '0;
            off_reg  <= '0;
            rep_reg  <= 1'b0;
        end
        else if (advance)
        begin
            for (int i = 0; i < PATTERN_BYTES; i++)
                recent_reg[i] <= win[i];
            seen_reg <= seen_next;
            off_reg  <= base_off;
            rep_reg  <= base_rep || last_eff || report_byte;
        end
    end

    // result queue, head drives the port
    assign push = advance && (report_byte || report_end);
    assign pop  = result.valid && result.ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= QUEUE_EMPTY;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            q0_status_reg   <= q1_status_reg;
            q0_position_reg <= q1_position_reg;
        end
        if (push)
        begin
            if ((count_reg == QUEUE_EMPTY) || (pop && (count_reg == QUEUE_ONE)))
            begin
                q0_status_reg   <= res_status;
                q0_position_reg <= res_position;
            end
            else
            begin
                q1_status_reg   <= res_status;
                q1_position_reg <= res_position;
            end
        end
    end

    assign result.valid    = (count_reg != QUEUE_EMPTY);
    assign result.status   = q0_status_reg;
    assign result.position = q0_position_reg;

endmodule

// ===== hw/rtl/lsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsm_checker
// Port-level checks for the substring matcher, bound to the top level.
// ----------------------------------------------------------------------------
module lsm_checker #(
    parameter int POSITION_BITS = lsm_pkg::POSITION_BITS_DEF
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     text_ready,
    input logic                     result_valid,
    input logic                     result_ready,
    input logic [1:0]               result_status,
    input logic [POSITION_BITS-1:0] result_position
);
    import lsm_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped without a transaction");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_status == STATUS_FOUND || result_status == STATUS_NOT_FOUND
                          || result_status == STATUS_TOO_LONG))
        else $error("result status out of range");

    a_position_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_status != STATUS_FOUND |-> result_position == '0)
        else $error("position nonzero on a miss");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !text_ready |-> result_valid)
        else $error("text stalled with no result pending");

endmodule

bind latin1_substring_matcher_top lsm_checker #(.POSITION_BITS(POSITION_BITS)) u_lsm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .text_ready      (text.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_status   (result.status),
    .result_position (result.position)
);
